// File: sv/wcbt_pkg.sv
// Shared types, constants and codes for the write-combining buffer tracker.
`timescale 1ns / 1ps

package wcbt_pkg;

    localparam int TAG_W            = 16;
    localparam int BYTE_ADDR_W      = 48;
    localparam int DRAIN_W          = 4;
    localparam int STALL_W          = 19;
    localparam int LATENCY_W        = 16;
    localparam int OUT_DATA_W       = 32;
    localparam int PADDR_W          = 3;
    localparam int PDATA_W          = 32;

    localparam logic [STALL_W-1:0] STALL_MAX = '1;

    localparam int BUFFER_COUNT_DEF   = 8;
    localparam int TABLE_SLOTS_DEF    = 32;
    localparam int LINE_BYTES_LOG_DEF = 6;

    localparam logic REG_WRITE_LATENCY = 1'b0;

    typedef enum logic {
        OP_STORE = 1'b0,
        OP_FLUSH = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REM,
        S_PROBE,
        S_MULT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             clear;
        logic             launch;
        logic             advance;
        logic [TAG_W-1:0] tag;
    } t_cell_ctl;

    typedef struct packed {
        logic hit;
        logic alloc;
    } t_cell_stat;

endpackage

// File: sv/wcbt_cell.sv
// One tag slot of the table, with the probe token that travels along the row of slots.
`timescale 1ns / 1ps

module wcbt_cell import wcbt_pkg::*; #(
    parameter int SLOT_W = 5,
    parameter int INDEX  = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctl         i_ctl,
    input  logic [SLOT_W-1:0] i_start,
    input  logic              i_pass,
    output logic              o_pass,
    output t_cell_stat        o_stat
);

    logic [TAG_W-1:0] r_tag;
    logic [TAG_W-1:0] n_tag;
    logic             r_token;
    logic             n_token;
    logic             w_match;
    logic             w_empty;

    assign w_match = r_token && (r_tag == i_ctl.tag);
    assign w_empty = r_token && (r_tag == '0) && !w_match;
    assign o_pass  = r_token && !w_match && !w_empty;
    assign o_stat  = '{hit: w_match, alloc: w_empty};

    always_comb begin
        n_tag = r_tag;
        if (i_ctl.clear) begin
            n_tag = '0;
        end else if (w_empty) begin
            n_tag = i_ctl.tag;
        end
        if (i_ctl.launch) begin
            n_token = (i_start == SLOT_W'(INDEX));
        end else if (i_ctl.advance) begin
            n_token = i_pass;
        end else begin
            n_token = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag   <= '0;
            r_token <= 1'b0;
        end else begin
            r_tag   <= n_tag;
            r_token <= n_token;
        end
    end

endmodule

// File: sv/wcbt_ctrl.sv
// Sequencer: drain decision, start slot, probe steps, occupancy, stall product and result register.
`timescale 1ns / 1ps

module wcbt_ctrl import wcbt_pkg::*; #(
    parameter int BUFFER_COUNT = BUFFER_COUNT_DEF,
    parameter int TABLE_SLOTS  = TABLE_SLOTS_DEF,
    parameter int SLOT_W       = $clog2(TABLE_SLOTS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_opcode              i_opcode,
    input  logic [TAG_W-1:0]     i_tag,
    input  logic [LATENCY_W-1:0] i_latency,
    input  t_cell_stat           i_stat,
    output t_cell_ctl            o_ctl,
    output logic [SLOT_W-1:0]    o_start,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_hit,
    output logic                 o_alloc,
    output logic [DRAIN_W-1:0]   o_drained,
    output logic [STALL_W-1:0]   o_stall
);

    localparam int  CNT_W = $clog2(BUFFER_COUNT + 1);
    localparam int  PRD_W = (CNT_W + LATENCY_W > STALL_W) ? CNT_W + LATENCY_W : STALL_W;
    localparam bit  POW2  = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);
    localparam logic [31:0] RECIP = 32'((1 << TAG_W) / TABLE_SLOTS);

    t_state             r_state,   n_state;
    logic [TAG_W-1:0]   r_tag,     n_tag;
    logic [TAG_W-1:0]   r_quot,    n_quot;
    logic [CNT_W-1:0]   r_count,   n_count;
    logic [CNT_W-1:0]   r_drained, n_drained;
    logic [SLOT_W-1:0]  r_step,    n_step;
    logic               r_hit,     n_hit;
    logic               r_alloc,   n_alloc;
    logic [PRD_W-1:0]   r_prod,    n_prod;
    logic               r_out_valid, n_out_valid;
    logic               r_out_hit;
    logic               r_out_alloc;
    logic [DRAIN_W-1:0] r_out_drained;
    logic [STALL_W-1:0] r_out_stall;
    logic               w_load;
    logic               w_accept;
    logic [TAG_W-1:0]   w_rem_est;
    logic [TAG_W-1:0]   w_rem_fix;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = o_in_ready && i_in_valid;
    assign w_load      = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    // The reciprocal quotient is at most one short, so one subtraction finishes the remainder.
    assign w_rem_est   = r_tag - TAG_W'(32'(r_quot) * 32'(TABLE_SLOTS));
    assign w_rem_fix   = (w_rem_est >= TAG_W'(TABLE_SLOTS)) ?
                         w_rem_est - TAG_W'(TABLE_SLOTS) : w_rem_est;

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_out_hit;
    assign o_alloc     = r_out_alloc;
    assign o_drained   = r_out_drained;
    assign o_stall     = r_out_stall;

    always_comb begin
        n_state     = r_state;
        n_tag       = r_tag;
        n_quot      = r_quot;
        n_count     = r_count;
        n_drained   = r_drained;
        n_step      = r_step;
        n_hit       = r_hit;
        n_alloc     = r_alloc;
        n_prod      = r_prod;
        o_ctl       = '0;
        o_ctl.tag   = r_tag;
        o_start     = '0;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_tag     = i_tag;
                    n_hit     = 1'b0;
                    n_alloc   = 1'b0;
                    n_drained = '0;
                    if (i_opcode == OP_FLUSH || r_count >= CNT_W'(BUFFER_COUNT)) begin
                        o_ctl.clear = 1'b1;
                        n_count     = '0;
                        n_drained   = r_count;
                    end
                    if (i_opcode == OP_FLUSH) begin
                        n_state = S_MULT;
                    end else if (POW2) begin
                        o_ctl.launch = 1'b1;
                        o_start      = i_tag[SLOT_W-1:0];
                        n_step       = '0;
                        n_state      = S_PROBE;
                    end else begin
                        n_quot  = TAG_W'((32'(i_tag) * RECIP) >> TAG_W);
                        n_state = S_REM;
                    end
                end
            end
            S_REM: begin
                o_ctl.launch = 1'b1;
                o_start      = w_rem_fix[SLOT_W-1:0];
                n_step       = '0;
                n_state      = S_PROBE;
            end
            S_PROBE: begin
                if (i_stat.hit) begin
                    n_hit   = 1'b1;
                    n_state = S_MULT;
                end else if (i_stat.alloc) begin
                    n_alloc = 1'b1;
                    n_count = r_count + 1'b1;
                    n_state = S_MULT;
                end else if (r_step == SLOT_W'(TABLE_SLOTS - 1)) begin
                    n_state = S_MULT;
                end else begin
                    o_ctl.advance = 1'b1;
                    n_step        = r_step + 1'b1;
                end
            end
            S_MULT: begin
                n_prod  = PRD_W'(r_drained) * PRD_W'(i_latency);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag     <= n_tag;
        r_quot    <= n_quot;
        r_drained <= n_drained;
        r_step    <= n_step;
        r_hit     <= n_hit;
        r_alloc   <= n_alloc;
        r_prod    <= n_prod;
        if (w_load) begin
            r_out_hit     <= r_hit;
            r_out_alloc   <= r_alloc;
            r_out_drained <= DRAIN_W'(r_drained);
            r_out_stall   <= (r_prod > PRD_W'(STALL_MAX)) ? STALL_MAX : r_prod[STALL_W-1:0];
        end
    end

endmodule

// File: sv/write_combining_buffer_tracker.sv
// Top level of the write-combining buffer tracker: configuration port, slot row and sequencer.
`timescale 1ns / 1ps

// Each streaming store is looked up by its 16-bit line tag in a row of TABLE_SLOTS slot cells;
// a probe token enters at slot (tag mod TABLE_SLOTS) and moves one cell per clock until it finds
// the tag or an empty slot, or every slot has been probed; a store probes at most n + 1 slots at
// an occupancy of n, never more than TABLE_SLOTS, and first works out the start-slot remainder
// in a separate step when TABLE_SLOTS is not a power of two, while a flush skips the probe. One
// item is in work at a time; the result sits in an output register, so the next item is taken as
// soon as the sequencer is back in idle. A store arriving with BUFFER_COUNT buffers open, and every
// flush, drains and clears all slots together and charges write_latency_cycles stall cycles
// per drained buffer, saturated to 19 bits. No clearing pass is needed after reset.
module write_combining_buffer_tracker import wcbt_pkg::*; #(
    parameter int BUFFER_COUNT   = BUFFER_COUNT_DEF,
    parameter int TABLE_SLOTS    = TABLE_SLOTS_DEF,
    parameter int LINE_BYTES_LOG = LINE_BYTES_LOG_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // byte_address [47:0]
    input  logic [BYTE_ADDR_W-1:0] i_s_axis_tdata,
    // opcode [0]
    input  logic                   i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // hit [0], allocated [1], drained_buffers [5:2], stall_cycles [24:6], zero [31:25]
    output logic [OUT_DATA_W-1:0]  o_m_axis_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready
);

    localparam int SLOT_W = $clog2(TABLE_SLOTS);

    logic [LATENCY_W-1:0] r_latency;
    logic [TAG_W-1:0]     w_tag;
    t_cell_ctl            w_ctl;
    logic [SLOT_W-1:0]    w_start;
    t_cell_stat           w_cell_stat [TABLE_SLOTS];
    logic                 w_pass      [TABLE_SLOTS];
    t_cell_stat           w_stat;
    logic                 w_hit;
    logic                 w_alloc;
    logic [DRAIN_W-1:0]   w_drained;
    logic [STALL_W-1:0]   w_stall;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_WRITE_LATENCY) ? PDATA_W'(r_latency) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latency <= '0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_WRITE_LATENCY) begin
            r_latency <= pwdata[LATENCY_W-1:0];
        end
    end

    assign w_tag = i_s_axis_tdata[LINE_BYTES_LOG +: TAG_W];

    for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
        wcbt_cell #(
            .SLOT_W (SLOT_W),
            .INDEX  (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_start (w_start),
            .i_pass  (w_pass[(g + TABLE_SLOTS - 1) % TABLE_SLOTS]),
            .o_pass  (w_pass[g]),
            .o_stat  (w_cell_stat[g])
        );
    end

    always_comb begin
        w_stat = '0;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            w_stat.hit   = w_stat.hit   | w_cell_stat[i].hit;
            w_stat.alloc = w_stat.alloc | w_cell_stat[i].alloc;
        end
    end

    wcbt_ctrl #(
        .BUFFER_COUNT (BUFFER_COUNT),
        .TABLE_SLOTS  (TABLE_SLOTS),
        .SLOT_W       (SLOT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_opcode    (t_opcode'(i_s_axis_tuser)),
        .i_tag       (w_tag),
        .i_latency   (r_latency),
        .i_stat      (w_stat),
        .o_ctl       (w_ctl),
        .o_start     (w_start),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_hit       (w_hit),
        .o_alloc     (w_alloc),
        .o_drained   (w_drained),
        .o_stall     (w_stall)
    );

    assign o_m_axis_tdata = OUT_DATA_W'({w_stall, w_drained, w_alloc, w_hit});

endmodule

// File: sv/wcbt_checker.sv
// Port-level checks for the write-combining buffer tracker, bound to the top level.
`timescale 1ns / 1ps

module wcbt_checker import wcbt_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_DATA_W-1:0]  o_m_axis_tdata,
    input logic                   pready
);

    // A result that is not taken stays on the bus unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("result changed or vanished while stalled");

    // A store either hits or allocates, never both.
    a_hit_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[0] && o_m_axis_tdata[1]))
        else $error("hit and allocated both set");

    // The tracker works on one transaction at a time.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input accepted again before the previous one finished");

    // The configuration port never inserts wait states.
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind write_combining_buffer_tracker wcbt_checker u_wcbt_checker (.*);
